// ===== hdl/tlmg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlmg_pkg
// Shared types, register map, mode codes and actuation plan tables for the
// thermal / latency mode governor.
// ----------------------------------------------------------------------------
package tlmg_pkg;

    localparam int TIME_W   = 48;
    localparam int DWELL_W  = 32;
    localparam int LEVEL_W  = 16;
    localparam int COUNT_W  = 32;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 3;
    localparam int NUM_DWELL = 5;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_LAT_ENTER = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LAT_EXIT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TH_ENTER  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TH_EXIT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOLD      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOCKOUT   = 3'd5;

    localparam logic [LEVEL_W-1:0] RST_LAT_ENTER = 16'd16384;
    localparam logic [LEVEL_W-1:0] RST_LAT_EXIT  = 16'd11469;
    localparam logic [LEVEL_W-1:0] RST_TH_ENTER  = 16'd13926;
    localparam logic [LEVEL_W-1:0] RST_TH_EXIT   = 16'd12288;
    localparam logic [LEVEL_W-1:0] RST_HOLD      = 16'd750;
    localparam logic [LEVEL_W-1:0] RST_LOCKOUT   = 16'd1000;

    // 0.95 in Q0.10
    localparam int DEGRADE_NUM   = 973;
    localparam int DEGRADE_SHIFT = 10;
    localparam int DEGRADE_PROD_W = LEVEL_W + DEGRADE_SHIFT;

    // modes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_LATENCY  = 2'd1;
    localparam logic [1:0] MODE_THERMAL  = 2'd2;
    localparam logic [1:0] MODE_DEGRADED = 2'd3;

    // dwell timer slots
    localparam int DW_LAT_ENTER = 0;
    localparam int DW_LAT_EXIT  = 1;
    localparam int DW_TH_ENTER  = 2;
    localparam int DW_TH_EXIT   = 3;
    localparam int DW_BOTH      = 4;

    // energy preference codes
    localparam logic [1:0] EPP_PERF          = 2'd0;
    localparam logic [1:0] EPP_BALANCE_PERF  = 2'd1;
    localparam logic [1:0] EPP_BALANCE_POWER = 2'd2;
    localparam logic [1:0] EPP_POWER         = 2'd3;

    // present mode codes
    localparam logic [1:0] PRESENT_AUTO      = 2'd0;
    localparam logic [1:0] PRESENT_IMMEDIATE = 2'd1;
    localparam logic [1:0] PRESENT_MAILBOX   = 2'd2;
    localparam logic [1:0] PRESENT_FIFO      = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] lat_rise_level;
        logic [LEVEL_W-1:0] lat_fall_level;
        logic [LEVEL_W-1:0] th_rise_level;
        logic [LEVEL_W-1:0] th_fall_level;
        logic [LEVEL_W-1:0] hold_time_ms;
        logic [LEVEL_W-1:0] lockout_time_ms;
    } tlmg_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  now_time_ms;
        logic               sample_valid;
        logic [LEVEL_W-1:0] pressure;
        logic [LEVEL_W-1:0] thermal_stress;
        logic [DWELL_W-1:0] dt;
    } tlmg_item_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic               mode_changed;
        logic [1:0]         energy_preference;
        logic [5:0]         min_perf_percent;
        logic [1:0]         present_mode;
        logic               use_compositor;
        logic [COUNT_W-1:0] transition_count;
    } tlmg_result_t;

    function automatic logic [1:0] plan_epp(input logic [1:0] mode);
        logic [1:0] r;
        case (mode)
            MODE_NORMAL:   r = EPP_BALANCE_PERF;
            MODE_LATENCY:  r = EPP_PERF;
            MODE_THERMAL:  r = EPP_BALANCE_POWER;
            default:       r = EPP_POWER;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] plan_perf(input logic [1:0] mode);
        logic [5:0] r;
        case (mode)
            MODE_NORMAL:   r = 6'd30;
            MODE_LATENCY:  r = 6'd60;
            MODE_THERMAL:  r = 6'd20;
            default:       r = 6'd10;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] plan_present(input logic [1:0] mode);
        logic [1:0] r;
        case (mode)
            MODE_NORMAL:   r = PRESENT_AUTO;
            MODE_LATENCY:  r = PRESENT_IMMEDIATE;
            MODE_THERMAL:  r = PRESENT_MAILBOX;
            default:       r = PRESENT_FIFO;
        endcase
        return r;
    endfunction

    function automatic logic plan_comp(input logic [1:0] mode);
        return (mode == MODE_LATENCY);
    endfunction

endpackage

// ===== hdl/tlmg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlmg_regs
// APB register file holding the hysteresis levels, hold and lockout times.
// ----------------------------------------------------------------------------
module tlmg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlmg_pkg::APB_AW-1:0]   paddr,
    input  logic [tlmg_pkg::APB_DW-1:0]   pwdata,
    output logic [tlmg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output tlmg_pkg::tlmg_cfg_t           cfg
);

    tlmg_pkg::tlmg_cfg_t                 cfg_reg;
    logic [tlmg_pkg::REG_IDX_W-1:0]      reg_idx;
    logic [tlmg_pkg::LEVEL_W-1:0]        wdata;
    logic                                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[tlmg_pkg::APB_AW-1:2];
    assign wdata   = pwdata[tlmg_pkg::LEVEL_W-1:0];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lat_rise_level  <= tlmg_pkg::RST_LAT_ENTER;
            cfg_reg.lat_fall_level  <= tlmg_pkg::RST_LAT_EXIT;
            cfg_reg.th_rise_level   <= tlmg_pkg::RST_TH_ENTER;
            cfg_reg.th_fall_level   <= tlmg_pkg::RST_TH_EXIT;
            cfg_reg.hold_time_ms    <= tlmg_pkg::RST_HOLD;
            cfg_reg.lockout_time_ms <= tlmg_pkg::RST_LOCKOUT;
        end else if (wr_en) begin
            case (reg_idx)
                tlmg_pkg::REG_LAT_ENTER: cfg_reg.lat_rise_level  <= wdata;
                tlmg_pkg::REG_LAT_EXIT:  cfg_reg.lat_fall_level  <= wdata;
                tlmg_pkg::REG_TH_ENTER:  cfg_reg.th_rise_level   <= wdata;
                tlmg_pkg::REG_TH_EXIT:   cfg_reg.th_fall_level   <= wdata;
                tlmg_pkg::REG_HOLD:      cfg_reg.hold_time_ms    <= wdata;
                tlmg_pkg::REG_LOCKOUT:   cfg_reg.lockout_time_ms <= wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            tlmg_pkg::REG_LAT_ENTER: prdata[tlmg_pkg::LEVEL_W-1:0] = cfg_reg.lat_rise_level;
            tlmg_pkg::REG_LAT_EXIT:  prdata[tlmg_pkg::LEVEL_W-1:0] = cfg_reg.lat_fall_level;
            tlmg_pkg::REG_TH_ENTER:  prdata[tlmg_pkg::LEVEL_W-1:0] = cfg_reg.th_rise_level;
            tlmg_pkg::REG_TH_EXIT:   prdata[tlmg_pkg::LEVEL_W-1:0] = cfg_reg.th_fall_level;
            tlmg_pkg::REG_HOLD:      prdata[tlmg_pkg::LEVEL_W-1:0] = cfg_reg.hold_time_ms;
            tlmg_pkg::REG_LOCKOUT:   prdata[tlmg_pkg::LEVEL_W-1:0] = cfg_reg.lockout_time_ms;
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== hdl/tlmg_intake.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlmg_intake
// Input register. Captures one event and works out its elapsed time against
// the previous event's timestamp, saturated to 32 bits.
// ----------------------------------------------------------------------------
module tlmg_intake (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlmg_pkg::TIME_W-1:0]   s_now_time_ms,
    input  logic                          s_sample_valid,
    input  logic [tlmg_pkg::LEVEL_W-1:0]  s_pressure,
    input  logic [tlmg_pkg::LEVEL_W-1:0]  s_thermal_stress,
    output logic                          item_valid,
    input  logic                          item_ready,
    output tlmg_pkg::tlmg_item_t          item
);

    logic                               hold_valid_reg;
    logic [tlmg_pkg::TIME_W-1:0]        last_time_reg;
    tlmg_pkg::tlmg_item_t               item_reg;
    tlmg_pkg::tlmg_item_t               item_next;
    logic [tlmg_pkg::TIME_W-1:0]        diff;
    logic                               s_xfer;

    assign s_ready    = !hold_valid_reg || item_ready;
    assign s_xfer     = s_valid && s_ready;
    assign item_valid = hold_valid_reg;
    assign item       = item_reg;
    assign diff       = s_now_time_ms - last_time_reg;

    always_comb begin
        item_next.now_time_ms    = s_now_time_ms;
        item_next.sample_valid   = s_sample_valid;
        item_next.pressure       = s_pressure;
        item_next.thermal_stress = s_thermal_stress;
        if (s_now_time_ms > last_time_reg) begin
            if (|diff[tlmg_pkg::TIME_W-1:tlmg_pkg::DWELL_W])
                item_next.dt = '1;
            else
                item_next.dt = diff[tlmg_pkg::DWELL_W-1:0];
        end else begin
            // time stood still or went backwards
            item_next.dt = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            last_time_reg  <= '0;
        end else if (s_xfer) begin
            hold_valid_reg <= 1'b1;
            last_time_reg  <= s_now_time_ms;
        end else if (item_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hdl/tlmg_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlmg_core
// Dwell timers, lockout and the four-mode governor; registers one result
// per event together with the actuation plan of the resulting mode.
// ----------------------------------------------------------------------------
module tlmg_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tlmg_pkg::tlmg_cfg_t           cfg,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  tlmg_pkg::tlmg_item_t          item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tlmg_pkg::tlmg_result_t        result
);

    localparam int NDW = tlmg_pkg::NUM_DWELL;
    localparam int DW  = tlmg_pkg::DWELL_W;
    localparam int TW  = tlmg_pkg::TIME_W;

    logic [1:0]                     mode_reg;
    logic [1:0]                     mode_next;
    logic [TW-1:0]                  lockout_reg;
    logic [DW-1:0]                  dwell_reg [NDW];
    logic [DW-1:0]                  dwell_adv [NDW];
    logic [tlmg_pkg::COUNT_W-1:0]   count_reg;
    logic                           m_valid_reg;
    tlmg_pkg::tlmg_result_t         result_reg;
    tlmg_pkg::tlmg_result_t         result_next;

    logic [NDW-1:0]                 cond;
    logic [NDW-1:0]                 held;
    logic [DW:0]                    dwell_sum [NDW];
    logic                           lat_hi;
    logic                           lat_lo;
    logic                           th_hi;
    logic                           th_lo;
    logic                           unlocked;
    logic                           change;
    logic                           take;
    logic [tlmg_pkg::DEGRADE_PROD_W-1:0] deg_prod;
    logic [tlmg_pkg::LEVEL_W-1:0]   deg_level;
    logic [TW:0]                    lock_sum;
    logic [TW-1:0]                  lock_next;
    logic [tlmg_pkg::COUNT_W-1:0]   count_next;

    assign take       = item_valid && (!m_valid_reg || m_ready);
    assign item_ready = take;
    assign m_valid    = m_valid_reg;
    assign result     = result_reg;

    assign lat_hi = item.pressure > cfg.lat_rise_level;
    assign lat_lo = item.pressure < cfg.lat_fall_level;
    assign th_hi  = item.thermal_stress > cfg.th_rise_level;
    assign th_lo  = item.thermal_stress < cfg.th_fall_level;

    assign cond[tlmg_pkg::DW_LAT_ENTER] = lat_hi;
    assign cond[tlmg_pkg::DW_LAT_EXIT]  = lat_lo;
    assign cond[tlmg_pkg::DW_TH_ENTER]  = th_hi;
    assign cond[tlmg_pkg::DW_TH_EXIT]   = th_lo;
    assign cond[tlmg_pkg::DW_BOTH]      = lat_lo && th_lo;

    // 0.95 of the thermal enter level for degraded entry
    assign deg_prod  = tlmg_pkg::DEGRADE_PROD_W'(cfg.th_rise_level)
                     * tlmg_pkg::DEGRADE_PROD_W'(tlmg_pkg::DEGRADE_NUM);
    assign deg_level = deg_prod[tlmg_pkg::DEGRADE_PROD_W-1:tlmg_pkg::DEGRADE_SHIFT];

    always_comb begin
        for (int k = 0; k < NDW; k++) begin
            dwell_sum[k] = {1'b0, dwell_reg[k]} + {1'b0, item.dt};
            if (!item.sample_valid || !cond[k])
                dwell_adv[k] = '0;
            else if (dwell_sum[k][DW])
                dwell_adv[k] = '1;
            else
                dwell_adv[k] = dwell_sum[k][DW-1:0];
            held[k] = dwell_adv[k] >= {{(DW-tlmg_pkg::LEVEL_W){1'b0}}, cfg.hold_time_ms};
        end
    end

    assign unlocked = item.now_time_ms >= lockout_reg;

    always_comb begin
        mode_next = mode_reg;
        case (mode_reg)
            tlmg_pkg::MODE_NORMAL: begin
                if (th_hi && held[tlmg_pkg::DW_TH_ENTER])
                    mode_next = tlmg_pkg::MODE_THERMAL;
                else if (lat_hi && held[tlmg_pkg::DW_LAT_ENTER])
                    mode_next = tlmg_pkg::MODE_LATENCY;
            end
            tlmg_pkg::MODE_LATENCY: begin
                // thermal pre-empts latency critical with no dwell
                if (th_hi)
                    mode_next = tlmg_pkg::MODE_THERMAL;
                else if (lat_lo && held[tlmg_pkg::DW_LAT_EXIT])
                    mode_next = tlmg_pkg::MODE_NORMAL;
            end
            tlmg_pkg::MODE_THERMAL: begin
                if (th_lo && held[tlmg_pkg::DW_TH_EXIT])
                    mode_next = tlmg_pkg::MODE_NORMAL;
                else if (lat_hi && held[tlmg_pkg::DW_LAT_ENTER]
                         && item.thermal_stress > deg_level)
                    mode_next = tlmg_pkg::MODE_DEGRADED;
            end
            default: begin
                if (cond[tlmg_pkg::DW_BOTH] && held[tlmg_pkg::DW_BOTH])
                    mode_next = tlmg_pkg::MODE_NORMAL;
            end
        endcase
    end

    assign change     = item.sample_valid && unlocked && (mode_next != mode_reg);
    assign lock_sum   = {1'b0, item.now_time_ms}
                      + {{(TW+1-tlmg_pkg::LEVEL_W){1'b0}}, cfg.lockout_time_ms};
    assign lock_next  = lock_sum[TW] ? '1 : lock_sum[TW-1:0];
    assign count_next = change ? count_reg + 1'b1 : count_reg;

    always_comb begin
        logic [1:0] m;
        m = change ? mode_next : mode_reg;
        result_next.mode              = m;
        result_next.mode_changed      = change;
        result_next.energy_preference = tlmg_pkg::plan_epp(m);
        result_next.min_perf_percent  = tlmg_pkg::plan_perf(m);
        result_next.present_mode      = tlmg_pkg::plan_present(m);
        result_next.use_compositor    = tlmg_pkg::plan_comp(m);
        result_next.transition_count  = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= tlmg_pkg::MODE_NORMAL;
            lockout_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NDW; k++) begin
                dwell_reg[k] <= '0;
            end
        end else begin
            if (take) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_next;
                if (change) begin
                    mode_reg    <= mode_next;
                    lockout_reg <= lock_next;
                end
                for (int k = 0; k < NDW; k++) begin
                    dwell_reg[k] <= change ? '0 : dwell_adv[k];
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== hdl/thermal_latency_mode_governor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_latency_mode_governor
// Four-mode governor driven by latency pressure and thermal stress, with
// dwell hysteresis, post-transition lockout and a per-mode actuation plan.
//
//   channel  | dir  | handshake        | payload
//   ---------+------+------------------+---------------------------------------
//   s_       | in   | s_valid/s_ready  | now_time_ms, sample_valid, pressures
//   m_       | out  | m_valid/m_ready  | mode, mode_changed, plan, count
//   apb      | in   | psel/penable     | six 16-bit registers at 4*index
//
// One event per cycle sustained while m_ready is held high; an input transfer
// passes the input register, then decision logic into the result register.
// Synchronous active-low reset restores register defaults, normal mode and
// clears timers, lockout and the transition count.
// A stalled result still lets one further event be taken into the input
// register; s_ready drops only while both registers are full.
// ----------------------------------------------------------------------------
module thermal_latency_mode_governor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlmg_pkg::APB_AW-1:0]   paddr,
    input  logic [tlmg_pkg::APB_DW-1:0]   pwdata,
    output logic [tlmg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlmg_pkg::TIME_W-1:0]   s_now_time_ms,
    input  logic                          s_sample_valid,
    input  logic [tlmg_pkg::LEVEL_W-1:0]  s_pressure,
    input  logic [tlmg_pkg::LEVEL_W-1:0]  s_thermal_stress,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_mode,
    output logic                          m_mode_changed,
    output logic [1:0]                    m_energy_preference,
    output logic [5:0]                    m_min_perf_percent,
    output logic [1:0]                    m_present_mode,
    output logic                          m_use_compositor,
    output logic [tlmg_pkg::COUNT_W-1:0]  m_transition_count
);

    tlmg_pkg::tlmg_cfg_t     cfg;
    tlmg_pkg::tlmg_item_t    item;
    tlmg_pkg::tlmg_result_t  result;
    logic                    item_valid;
    logic                    item_ready;

    tlmg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlmg_intake u_intake (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_now_time_ms    (s_now_time_ms),
        .s_sample_valid   (s_sample_valid),
        .s_pressure       (s_pressure),
        .s_thermal_stress (s_thermal_stress),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item)
    );

    tlmg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_mode              = result.mode;
    assign m_mode_changed      = result.mode_changed;
    assign m_energy_preference = result.energy_preference;
    assign m_min_perf_percent  = result.min_perf_percent;
    assign m_present_mode      = result.present_mode;
    assign m_use_compositor    = result.use_compositor;
    assign m_transition_count  = result.transition_count;

    // input side only backs up when the result is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled result");

    // the compositor is used exactly in latency critical mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_use_compositor == (m_mode == tlmg_pkg::MODE_LATENCY)))
        else $error("compositor plan does not match mode");

    // a handed-over item reaches the result register on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item_ready) |=> m_valid)
        else $error("accepted event produced no result");

endmodule
